/* rtl/rtdc_pkg.sv */
// ----------------------------------------------------------------------------
// rtdc_pkg - shared types and constants
// Widths, register map codes and fixed-point constants of the RTD converter.
// ----------------------------------------------------------------------------
package rtdc_pkg;

    localparam int CHANNELS = 3;
    localparam int CH_IW    = 2;

    // register map, index = paddr[4:2]
    localparam logic [2:0] REG_REF   = 3'd0;
    localparam logic [2:0] REG_GAIN0 = 3'd1;
    localparam logic [2:0] REG_GAIN2 = 3'd3;
    localparam logic [2:0] REG_OFF0  = 3'd4;
    localparam logic [2:0] REG_OFF2  = 3'd6;

    localparam logic [16:0] REF_RST  = 17'd68800;
    localparam logic [15:0] GAIN_RST = 16'd16384;

    // square root chain: 58-bit radicand, one root bit per cell
    localparam int SQ_DW = 58;
    localparam int SQ_RW = 29;
    localparam int SQ_MW = 31;

    localparam logic [43:0] DISC_BASE = 44'd15274808890000;
    localparam logic [27:0] DISC_STEP = 28'd144375000;
    localparam logic [28:0] ROOT_BASE = 29'd390830000;

    typedef struct packed {
        logic [1:0]  channel;
        logic [7:0]  fault;
        logic [16:0] r16;
        logic        ok;
        logic        lin;
        logic [14:0] lin_q;
    } t_side;

endpackage

/* rtl/rtdc_if.sv */
// ----------------------------------------------------------------------------
// rtdc_if - item channels
// Sample channel into the converter and result channel out of it.
// ----------------------------------------------------------------------------
interface rtdc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  channel;
    logic [15:0] raw_code;
    logic [7:0]  fault_status;

    modport source (output valid, channel, raw_code, fault_status, input ready);
    modport sink   (input valid, channel, raw_code, fault_status, output ready);
endinterface

interface rtdc_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         channel_echo;
    logic [16:0]        resistance;
    logic signed [17:0] raw_temperature;
    logic               raw_temperature_ok;
    logic signed [17:0] temperature;
    logic               reading_valid;
    logic [7:0]         fault_echo;
    logic               clear_fault_request;

    modport source (output valid, channel_echo, resistance, raw_temperature,
                    raw_temperature_ok, temperature, reading_valid, fault_echo,
                    clear_fault_request, input ready);
    modport sink   (input valid, channel_echo, resistance, raw_temperature,
                    raw_temperature_ok, temperature, reading_valid, fault_echo,
                    clear_fault_request, output ready);
endinterface

/* rtl/rtd_pt1000_temperature_convert.sv */
// ----------------------------------------------------------------------------
// rtd_pt1000_temperature_convert - Pt1000 RTD code to calibrated temperature
// Pipeline: 5 front stages, 29 square root cells and 5 back stages; the root
//   chain sets the depth.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset (synchronous, active low): pipeline empties, configuration registers take defaults.
// ----------------------------------------------------------------------------
module rtd_pt1000_temperature_convert
    import rtdc_pkg::*;
#(
    parameter logic signed [17:0] TEMP_MIN = -18'sd2560,
    parameter logic signed [17:0] TEMP_MAX = 18'sd9600
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rtdc_in_if.sink     i_in,
    rtdc_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [16:0] r_ref;
    logic [15:0] r_gain [CHANNELS];
    logic [13:0] r_off  [CHANNELS];
    logic [2:0]  w_idx;

    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= REF_RST;
            for (int i = 0; i < CHANNELS; i++) begin
                r_gain[i] <= GAIN_RST;
                r_off[i]  <= '0;
            end
        end else if (psel && penable && pwrite) begin
            case (w_idx) inside
                REG_REF:               r_ref <= pwdata[16:0];
                [REG_GAIN0:REG_GAIN2]: r_gain[CH_IW'(w_idx - REG_GAIN0)] <= pwdata[15:0];
                [REG_OFF0:REG_OFF2]:   r_off[CH_IW'(w_idx - REG_OFF0)]   <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx) inside
            REG_REF:               prdata = 32'(r_ref);
            [REG_GAIN0:REG_GAIN2]: prdata = 32'(r_gain[CH_IW'(w_idx - REG_GAIN0)]);
            [REG_OFF0:REG_OFF2]:   prdata = 32'(r_off[CH_IW'(w_idx - REG_OFF0)]);
            default:               prdata = '0;
        endcase
    end

    // every stage advances together unless the output holds an untaken result
    logic w_en;
    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;

    // front: resistance, range checks, linear fit, discriminant
    logic             w_f_vld;
    logic [SQ_DW-1:0] w_disc;
    t_side            w_f_side;

    rtdc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_in.valid),
        .i_channel  (i_in.channel),
        .i_raw_code (i_in.raw_code),
        .i_fault    (i_in.fault_status),
        .i_ref      (r_ref),
        .o_valid    (w_f_vld),
        .o_disc     (w_disc),
        .o_side     (w_f_side)
    );

    // square root chain: cell k settles root bit 28-k
    logic             w_c_vld  [SQ_RW+1];
    logic [SQ_MW-1:0] w_c_rem  [SQ_RW+1];
    logic [SQ_RW-1:0] w_c_root [SQ_RW+1];
    logic [SQ_DW-1:0] w_c_data [SQ_RW+1];
    t_side            w_c_side [SQ_RW+1];

    assign w_c_vld[0]  = w_f_vld;
    assign w_c_rem[0]  = '0;
    assign w_c_root[0] = '0;
    assign w_c_data[0] = w_disc;
    assign w_c_side[0] = w_f_side;

    for (genvar k = 0; k < SQ_RW; k++) begin : g_cell
        rtdc_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_c_vld[k]),
            .i_rem   (w_c_rem[k]),
            .i_root  (w_c_root[k]),
            .i_data  (w_c_data[k]),
            .i_side  (w_c_side[k]),
            .o_valid (w_c_vld[k+1]),
            .o_rem   (w_c_rem[k+1]),
            .o_root  (w_c_root[k+1]),
            .o_data  (w_c_data[k+1]),
            .o_side  (w_c_side[k+1])
        );
    end

    // back: divide by 115500, calibration, plausibility window
    rtdc_back #(
        .TEMP_MIN (TEMP_MIN),
        .TEMP_MAX (TEMP_MAX)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_en),
        .i_valid         (w_c_vld[SQ_RW]),
        .i_root          (w_c_root[SQ_RW]),
        .i_side          (w_c_side[SQ_RW]),
        .i_gain          (r_gain),
        .i_off           (r_off),
        .o_valid         (o_out.valid),
        .o_channel       (o_out.channel_echo),
        .o_resistance    (o_out.resistance),
        .o_raw_temp      (o_out.raw_temperature),
        .o_raw_ok        (o_out.raw_temperature_ok),
        .o_temp          (o_out.temperature),
        .o_reading_valid (o_out.reading_valid),
        .o_fault         (o_out.fault_echo),
        .o_clear         (o_out.clear_fault_request)
    );

    // a waiting result blocks new items
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("item accepted while result stalled");

    // a valid reading needs a computed temperature
    a_valid_needs_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.reading_valid) |-> o_out.raw_temperature_ok)
        else $error("reading valid without raw temperature");

    // a faulted sample never carries a temperature
    a_fault_no_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.clear_fault_request) |-> !o_out.raw_temperature_ok)
        else $error("temperature computed for faulted sample");

    // pipeline empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result present after reset");

endmodule

/* rtl/rtdc_front.sv */
// ----------------------------------------------------------------------------
// rtdc_front - resistance, linear fit and discriminant
// Five stages: ratio*Rref, rounding and range checks, then the linear
// divide-by-77 and the 58-bit discriminant for the square root chain.
// ----------------------------------------------------------------------------
module rtdc_front
    import rtdc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [1:0]       i_channel,
    input  logic [15:0]      i_raw_code,
    input  logic [7:0]       i_fault,
    input  logic [16:0]      i_ref,
    output logic             o_valid,
    output logic [SQ_DW-1:0] o_disc,
    output t_side            o_side
);

    logic [4:0]  r_vld;
    // stage 0
    logic [31:0] r_p;
    logic [1:0]  r_ch0;
    logic [7:0]  r_f0;
    logic        r_nz0;
    // stage 1
    logic [16:0] r_r16_1;
    logic [1:0]  r_ch1;
    logic [7:0]  r_f1;
    logic        r_ok1, r_lin1;
    logic [20:0] r_linx1;
    logic [15:0] r_d1;
    // stage 2
    t_side       r_s2;
    logic [20:0] r_linx2;
    logic [43:0] r_m2;
    logic [35:0] r_linp2;
    // stage 3
    t_side       r_s3;
    logic [20:0] r_linx3;
    logic [43:0] r_d03;
    logic [14:0] r_linq3;
    // stage 4
    t_side            r_s4;
    logic [SQ_DW-1:0] r_disc4;

    logic [32:0] n_sum;
    logic [16:0] n_r16;
    logic [13:0] n_diff;
    logic [57:0] n_dw;
    logic [21:0] n_lrem;
    t_side       n_s4;

    always_comb begin
        n_sum  = 33'(r_p) + 33'd16384;
        n_r16  = n_sum[31:15];
        n_diff = 14'(17'd16000 - n_r16);
        n_dw   = 58'(r_d03);
        n_lrem = 22'(r_linx3) - 22'(r_linq3) * 22'd77;
        n_s4       = r_s3;
        n_s4.lin_q = r_linq3 + 15'(n_lrem >= 22'd77);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p   <= 32'(i_raw_code[15:1]) * 32'(i_ref);
            r_ch0 <= i_channel;
            r_f0  <= i_fault;
            r_nz0 <= (i_raw_code[15:1] != 15'd0);

            r_r16_1 <= n_r16;
            r_ch1   <= r_ch0;
            r_f1    <= r_f0;
            r_ok1   <= r_nz0 && (r_f0 == 8'd0) && (n_r16 >= 17'd1600)
                       && (n_r16 <= 17'd80000);
            r_lin1  <= (n_r16 < 17'd16000);
            r_linx1 <= (21'(n_diff) << 6) + (21'(n_diff) << 4) + 21'd38;
            r_d1    <= 16'(n_r16 - 17'd16000);

            r_s2.channel <= r_ch1;
            r_s2.fault   <= r_f1;
            r_s2.r16     <= r_r16_1;
            r_s2.ok      <= r_ok1;
            r_s2.lin     <= r_lin1;
            r_s2.lin_q   <= '0;
            r_linx2      <= r_linx1;
            r_m2         <= 44'(DISC_STEP) * 44'(r_d1);
            r_linp2      <= 36'(r_linx1) * 36'd27235;

            r_s3    <= r_s2;
            r_linx3 <= r_linx2;
            r_d03   <= DISC_BASE - r_m2;
            r_linq3 <= r_linp2[35:21];

            // times 10000 = 8192 + 1024 + 512 + 256 + 16
            r_disc4 <= (n_dw << 13) + (n_dw << 10) + (n_dw << 9) + (n_dw << 8)
                       + (n_dw << 4);
            r_s4    <= n_s4;
        end
    end

    assign o_valid = r_vld[4];
    assign o_disc  = r_disc4;
    assign o_side  = r_s4;

endmodule

/* rtl/rtdc_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// rtdc_sqrt_cell - one root bit of the integer square root
// Brings in the next two radicand bits, tries the subtract, passes on.
// ----------------------------------------------------------------------------
module rtdc_sqrt_cell
    import rtdc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [SQ_MW-1:0] i_rem,
    input  logic [SQ_RW-1:0] i_root,
    input  logic [SQ_DW-1:0] i_data,
    input  t_side            i_side,
    output logic             o_valid,
    output logic [SQ_MW-1:0] o_rem,
    output logic [SQ_RW-1:0] o_root,
    output logic [SQ_DW-1:0] o_data,
    output t_side            o_side
);

    logic             r_vld;
    logic [SQ_MW-1:0] r_rem;
    logic [SQ_RW-1:0] r_root;
    logic [SQ_DW-1:0] r_data;
    t_side            r_side;

    logic [SQ_MW+1:0] n_cur, n_trial, n_diff;
    logic             n_ge;

    always_comb begin
        n_cur   = {i_rem, i_data[SQ_DW-1 -: 2]};
        n_trial = {2'b00, i_root, 2'b01};
        n_diff  = n_cur - n_trial;
        n_ge    = (n_cur >= n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_ge ? n_diff[SQ_MW-1:0] : n_cur[SQ_MW-1:0];
            r_root <= {i_root[SQ_RW-2:0], n_ge};
            r_data <= {i_data[SQ_DW-3:0], 2'b00};
            r_side <= i_side;
        end
    end

    assign o_valid = r_vld;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_data  = r_data;
    assign o_side  = r_side;

endmodule

/* rtl/rtdc_back.sv */
// ----------------------------------------------------------------------------
// rtdc_back - quadratic scaling, calibration and output register
// Divide by 115500 through a reciprocal, gain/offset, saturate, validity.
// ----------------------------------------------------------------------------
module rtdc_back
    import rtdc_pkg::*;
#(
    parameter logic signed [17:0] TEMP_MIN = -18'sd2560,
    parameter logic signed [17:0] TEMP_MAX = 18'sd9600
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [SQ_RW-1:0]   i_root,
    input  t_side              i_side,
    input  logic [15:0]        i_gain [CHANNELS],
    input  logic [13:0]        i_off  [CHANNELS],
    output logic               o_valid,
    output logic [1:0]         o_channel,
    output logic [16:0]        o_resistance,
    output logic signed [17:0] o_raw_temp,
    output logic               o_raw_ok,
    output logic signed [17:0] o_temp,
    output logic               o_reading_valid,
    output logic [7:0]         o_fault,
    output logic               o_clear
);

    logic [4:0]         r_vld;
    t_side              r_s0, r_s1, r_s2, r_s3;
    logic [31:0]        r_y0, r_y1;
    logic [17:0]        r_q01;
    logic [16:0]        r_q2;
    logic signed [17:0] r_raw3;
    logic signed [34:0] r_prod3;
    logic signed [13:0] r_off3;

    logic [28:0]        n_num;
    logic [34:0]        n_x;
    logic [49:0]        n_rp;
    logic [32:0]        n_chk;
    logic [CH_IW-1:0]   n_cal;
    logic signed [17:0] n_raw;
    logic signed [34:0] n_rnd;
    logic signed [20:0] n_scaled;
    logic signed [21:0] n_sum;
    logic signed [17:0] n_sat;

    always_comb begin
        n_num    = ROOT_BASE - i_root;
        n_x      = {n_num, 6'b0} + 35'd57750;
        n_rp     = 50'(r_y0) * 50'd148743;
        n_chk    = 33'(r_y1) - 33'(r_q01) * 33'd28875;
        n_cal    = (r_s2.channel < CH_IW'(CHANNELS)) ? r_s2.channel : '0;
        n_raw    = !r_s2.ok ? 18'sd0
                 : r_s2.lin ? -$signed(18'(r_s2.lin_q)) : $signed(18'(r_q2));
        n_rnd    = r_prod3 + 35'sd8192;
        n_scaled = 21'(n_rnd >>> 14);
        n_sum    = 22'(n_scaled) + 22'(r_off3);
        if (n_sum > 22'sd131071) begin
            n_sat = 18'sd131071;
        end else if (n_sum < -22'sd131072) begin
            n_sat = -18'sd131072;
        end else begin
            n_sat = 18'(n_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0 <= i_side;
            r_y0 <= n_x[33:2];

            r_s1  <= r_s0;
            r_y1  <= r_y0;
            r_q01 <= n_rp[49:32];

            r_s2 <= r_s1;
            r_q2 <= 17'(r_q01) + 17'(n_chk >= 33'd28875);

            r_s3    <= r_s2;
            r_raw3  <= n_raw;
            r_prod3 <= 35'(n_raw) * $signed({19'b0, i_gain[n_cal]});
            r_off3  <= $signed(i_off[n_cal]);

            o_channel       <= r_s3.channel;
            o_resistance    <= r_s3.r16;
            o_raw_temp      <= r_raw3;
            o_raw_ok        <= r_s3.ok;
            o_temp          <= r_s3.ok ? n_sat : 18'sd0;
            o_reading_valid <= r_s3.ok && (n_sat >= TEMP_MIN) && (n_sat <= TEMP_MAX);
            o_fault         <= r_s3.fault;
            o_clear         <= (r_s3.fault != 8'd0);
        end
    end

    assign o_valid = r_vld[4];

endmodule

/* bench/tb_rtd_pt1000_temperature_convert.sv */
// ----------------------------------------------------------------------------
// tb_rtd_pt1000_temperature_convert - self-checking bench for the RTD converter
// Drives samples through several calibration settings, predicts each result
// in fixed point, and checks every result field against the prediction.
// ----------------------------------------------------------------------------
module tb_rtd_pt1000_temperature_convert;
    import rtdc_pkg::*;

    localparam int  CAL_MIN    = -2560;   // plausibility window, 1/64 degC
    localparam int  CAL_MAX    = 9600;
    localparam int  LIMIT      = 300000;  // cycle ceiling for the whole run
    localparam int  DRAIN      = 60;      // beyond the pipeline depth
    localparam int  HOLD_LEN   = 300;     // long receiver hold-off
    localparam logic [2:0] REG_NONE = 3'd7;  // unmapped index, write ignored

    typedef struct {
        logic [1:0]  channel;
        logic [15:0] raw_code;
        logic [7:0]  fault;
    } t_sample;

    typedef struct {
        logic [1:0]         channel;
        logic [16:0]        resistance;
        logic signed [17:0] raw_temp;
        logic               raw_ok;
        logic signed [17:0] temp;
        logic               valid;
        logic [7:0]         fault;
        logic               clear_req;
    } t_reading;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rtdc_in_if  in_ch ();
    rtdc_out_if out_ch ();

    rtd_pt1000_temperature_convert DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // local copy of the calibration registers
    logic [16:0]        ref_res;
    logic [15:0]        gain   [CHANNELS];
    logic signed [13:0] offset [CHANNELS];

    t_sample  samples_pending[$];
    t_reading readings_due[$];
    int       errors;
    int       cycles;
    bit       calm;        // no idling on either side
    bit       hold_armed;  // next result starts a long hold-off
    int       hold_left;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---- fixed-point conversion -------------------------------------------

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint fdiv(longint p, longint q);
        longint r;
        r = p / q;
        if ((p % q) != 0 && p < 0) r = r - 1;
        return r;
    endfunction

    function automatic t_reading convert_sample(t_sample s);
        t_reading r;
        longint unsigned ratio, r16, s_root;
        longint raw, t, d, disc;
        int cal;
        bit ok;
        ratio = s.raw_code >> 1;
        r16   = (ratio * ref_res + 16384) >> 15;
        cal   = (s.channel < CHANNELS) ? int'(s.channel) : 0;
        ok    = 1'b0;
        raw   = 0;
        t     = 0;
        if (ratio > 0 && s.fault == 0 && r16 >= 1600 && r16 <= 80000) begin
            if (r16 < 16000) begin
                // linear fit below 1000 ohm
                raw = -(((16000 - longint'(r16)) * 80 + 38) / 77);
                ok  = 1'b1;
            end else begin
                // inverse quadratic, discriminant in 1e-18 units
                d    = longint'(r16) - 16000;
                disc = 64'sd15274808890000 - 64'sd144375000 * d;
                if (disc >= 0) begin
                    s_root = isqrt(longint'(disc) * 10000);
                    raw = fdiv((390830000 - longint'(s_root)) * 64 + 57750, 115500);
                    ok  = 1'b1;
                end
            end
        end
        if (ok) begin
            t = fdiv(raw * longint'(gain[cal]) + 8192, 16384) + longint'(offset[cal]);
            if (t > 131071)  t = 131071;
            if (t < -131072) t = -131072;
        end
        r.channel    = s.channel;
        r.resistance = r16[16:0];
        r.raw_temp   = raw[17:0];
        r.raw_ok     = ok;
        r.temp       = t[17:0];
        r.valid      = ok && t >= CAL_MIN && t <= CAL_MAX;
        r.fault      = s.fault;
        r.clear_req  = s.fault != 0;
        return r;
    endfunction

    // ---- sample driver ----------------------------------------------------

    always @(posedge i_clk) begin
        t_sample s;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                s.channel  = in_ch.channel;
                s.raw_code = in_ch.raw_code;
                s.fault    = in_ch.fault_status;
                readings_due.push_back(convert_sample(s));
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (samples_pending.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
                    s = samples_pending.pop_front();
                    in_ch.channel      <= s.channel;
                    in_ch.raw_code     <= s.raw_code;
                    in_ch.fault_status <= s.fault;
                    in_ch.valid        <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---- result monitor ---------------------------------------------------

    task automatic check_field(string name, longint e, longint a);
        if (e != a) begin
            errors++;
            $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, e, a);
        end
    endtask

    always @(posedge i_clk) begin
        t_reading e;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left    <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (readings_due.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result: expected none, actual channel %0d",
                             $time, out_ch.channel_echo);
                end else begin
                    e = readings_due.pop_front();
                    check_field("channel_echo", e.channel, out_ch.channel_echo);
                    check_field("resistance", e.resistance, out_ch.resistance);
                    check_field("raw_temperature", e.raw_temp, out_ch.raw_temperature);
                    check_field("raw_temperature_ok", e.raw_ok, out_ch.raw_temperature_ok);
                    check_field("temperature", e.temp, out_ch.temperature);
                    check_field("reading_valid", e.valid, out_ch.reading_valid);
                    check_field("fault_echo", e.fault, out_ch.fault_echo);
                    check_field("clear_fault_request", e.clear_req,
                                out_ch.clear_fault_request);
                end
            end
            if (hold_armed && out_ch.valid && out_ch.ready) begin
                hold_armed   = 1'b0;
                hold_left    <= HOLD_LEN;
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm || $urandom_range(99) >= 30;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ---- configuration and stimulus --------------------------------------

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_REF) begin
            ref_res = val[16:0];
        end else if (idx >= REG_GAIN0 && idx <= REG_GAIN2) begin
            gain[idx - REG_GAIN0] = val[15:0];
        end else if (idx >= REG_OFF0 && idx <= REG_OFF2) begin
            offset[idx - REG_OFF0] = val[13:0];
        end
    endtask

    task automatic add_sample(logic [1:0] ch, logic [15:0] code, logic [7:0] fault);
        t_sample s;
        s.channel  = ch;
        s.raw_code = code;
        s.fault    = fault;
        samples_pending.push_back(s);
    endtask

    // mostly in-range codes, some raw noise, some faults
    task automatic add_random(int n);
        logic [15:0] code;
        logic [7:0]  fault;
        repeat (n) begin
            if ($urandom_range(99) < 75)
                code = {15'($urandom_range(32767, 700)), 1'($urandom)};
            else
                code = 16'($urandom);
            fault = ($urandom_range(99) < 12) ? 8'($urandom) : 8'd0;
            add_sample(2'($urandom), code, fault);
        end
    endtask

    // all issued samples accepted and every result back
    task automatic wait_idle();
        while (samples_pending.size() != 0 || in_ch.valid || readings_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(int n);
        add_random(n);
        wait_idle();
        repeat (DRAIN) @(posedge i_clk);
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        calm = 1'b0;
        hold_armed = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.channel = '0;
        in_ch.raw_code = '0;
        in_ch.fault_status = '0;
        out_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        ref_res = REF_RST;
        for (int c = 0; c < CHANNELS; c++) begin
            gain[c]   = GAIN_RST;
            offset[c] = '0;
        end
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero ratio, field extremes, both fits, range edges, faults
        add_sample(2'd0, 16'h0000, 8'h00);
        add_sample(2'd1, 16'h0001, 8'h00);
        add_sample(2'd2, 16'hFFFF, 8'h00);
        add_sample(2'd3, 16'hFFFE, 8'h00);
        add_sample(2'd0, 16'd1522, 8'h00);   // just under 100 ohm
        add_sample(2'd0, 16'd1526, 8'h00);   // about 100 ohm
        add_sample(2'd1, 16'd15240, 8'h00);  // just under 1000 ohm
        add_sample(2'd1, 16'd15242, 8'h00);  // at 1000 ohm, quadratic
        add_sample(2'd2, 16'd15243, 8'h00);
        add_sample(2'd2, 16'd20000, 8'h00);
        add_sample(2'd0, 16'd60000, 8'h00);  // high end of the code range
        add_sample(2'd0, 16'd65534, 8'h00);
        add_sample(2'd1, 16'd20000, 8'h01);
        add_sample(2'd2, 16'd20000, 8'hFF);
        add_sample(2'd3, 16'd30000, 8'h80);
        add_sample(2'd3, 16'd18000, 8'h00);  // channel 3 uses channel 0 cal
        add_sample(2'd0, 16'h5555, 8'h55);
        add_sample(2'd1, 16'hAAAA, 8'hAA);
        wait_idle();
        repeat (DRAIN) @(posedge i_clk);

        run_phase(150);

        // extremes: largest and zero gains, largest and smallest offsets, largest reference
        reg_write(REG_REF, 32'd131071);
        reg_write(REG_GAIN0, 32'd65535);
        reg_write(REG_GAIN0 + 3'd1, 32'd0);
        reg_write(REG_GAIN2, 32'd65535);
        reg_write(REG_OFF0, 32'd8191);
        reg_write(REG_OFF0 + 3'd1, 32'h3FFF_E000);  // -8192 in 14 bits
        reg_write(REG_OFF2, 32'd8191);
        reg_write(REG_NONE, 32'($urandom));
        calm = 1'b1;       // back-to-back stretch, then a long hold-off
        hold_armed = 1'b1;
        run_phase(160);
        calm = 1'b0;

        // smallest reference, then random
        reg_write(REG_REF, 32'd0);
        run_phase(40);

        reg_write(REG_REF, 32'd68800);
        reg_write(REG_GAIN0, 32'd0);
        reg_write(REG_OFF0, 32'h0000_2000);  // -8192
        reg_write(REG_OFF2, 32'd0);
        run_phase(150);

        for (int p = 0; p < 3; p++) begin
            reg_write(REG_REF, $urandom_range(131071, 40000));
            for (int c = 0; c < CHANNELS; c++) begin
                reg_write(REG_GAIN0 + 3'(c), $urandom_range(20000, 12000));
                reg_write(REG_OFF0 + 3'(c), 32'($urandom));
            end
            run_phase(150);
        end

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/rtdc_pkg.sv
rtl/rtdc_if.sv
rtl/rtdc_front.sv
rtl/rtdc_sqrt_cell.sv
rtl/rtdc_back.sv
rtl/rtd_pt1000_temperature_convert.sv
bench/tb_rtd_pt1000_temperature_convert.sv
